// ===== sv/backend_server_selector_unit_defines.svh =====
// Assertion macros used by the selector engine RTL.
`ifndef BACKEND_SERVER_SELECTOR_UNIT_DEFINES_SVH
`define BACKEND_SERVER_SELECTOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define BSS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BSS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bss_pkg.sv =====
package bss_pkg;

   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam int DIV_STEPS   = 32;
   localparam int DIV_CNT_W   = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT = 2'd1;

   typedef enum logic [1:0] {
      MODE_RR    = 2'd0,
      MODE_WRR   = 2'd1,
      MODE_LEAST = 2'd2,
      MODE_HASH  = 2'd3
   } mode_type;

   typedef enum logic {
      CMD_UPDATE = 1'b0,
      CMD_SELECT = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   slot;
      logic [15:0]  weight;
      logic [15:0]  sessions;
      logic [31:0]  addr;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_WALK,
      ST_LEAST,
      ST_RESP
   } state_type;

endpackage

// ===== sv/bss_ram.sv =====
module bss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/bss_front.sv =====
module bss_front #(
   parameter int MAX_SERVERS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bss_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,
   output logic                            cmd_valid,
   output bss_pkg::cmd_type                cmd,
   input  logic                            cmd_pop
);

   bss_pkg::cmd_type                 queue_ff [bss_pkg::QUEUE_DEPTH];
   logic [bss_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [bss_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [bss_pkg::QCNT_W-1:0]       count_ff, count_in;
   bss_pkg::cmd_type                 incoming;
   logic                             accept;
   logic                             push;

   always_comb begin
      incoming.kind     = bss_pkg::cmd_kind_type'(req_tuser);
      incoming.slot     = req_tdata[3:0];
      incoming.weight   = req_tdata[19:4];
      incoming.sessions = req_tdata[35:20];
      incoming.addr     = req_tdata[67:36];
   end

   assign req_tready = (count_ff != bss_pkg::QCNT_W'(bss_pkg::QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;
   // drop updates aimed past the table
   assign push       = accept && ((incoming.kind == bss_pkg::CMD_SELECT) ||
                                  (32'(incoming.slot) < 32'(MAX_SERVERS)));

   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + bss_pkg::QCNT_W'(push) - bss_pkg::QCNT_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

// ===== sv/bss_divider.sv =====
module bss_divider #(
   parameter int SUM_W = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [31:0]      dividend,
   input  logic [SUM_W-1:0] divisor,
   output logic             done,
   output logic [SUM_W-1:0] remainder
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [bss_pkg::DIV_CNT_W-1:0] step_ff, step_in;
   logic [31:0]                   dvd_ff, dvd_in;
   logic [SUM_W-1:0]              dvs_ff, dvs_in;
   logic [SUM_W-1:0]              rem_ff, rem_in;
   logic [SUM_W:0]                trial;
   logic [SUM_W:0]                diff;

   assign trial = {rem_ff, dvd_ff[31]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[30:0], 1'b0};
         rem_in  = (trial >= {1'b0, dvs_ff}) ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == bss_pkg::DIV_CNT_W'(bss_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== sv/bss_engine.sv =====
`include "backend_server_selector_unit_defines.svh"

module bss_engine #(
   parameter int MAX_SERVERS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   input  bss_pkg::cmd_type                cmd,
   output logic                            cmd_pop,
   input  bss_pkg::mode_type               mode,
   input  logic [4:0]                      server_count,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bss_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tuser
);

   localparam int SLOT_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CNT_W  = $clog2(MAX_SERVERS + 1);
   localparam int SUM_W  = 16 + SLOT_W;
   localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_SERVERS);

   bss_pkg::state_type state_ff, state_in;
   logic [31:0]        counter_ff, counter_in;
   logic [31:0]        wrr_dvd_ff, wrr_dvd_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SUM_W-1:0]   walk_ff, walk_in;
   logic [SLOT_W-1:0]  best_ff, best_in;
   logic [15:0]        best_val_ff, best_val_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               rd_last_ff, rd_last_in;
   logic [SLOT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [3:0]         res_slot_ff, res_slot_in;
   logic               res_none_ff, res_none_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         rsp_slot_ff, rsp_slot_in;
   logic               rsp_none_ff, rsp_none_in;

   logic [CNT_W-1:0]   n;
   logic               wr_en;
   logic [SLOT_W-1:0]  wr_addr;
   logic [SLOT_W-1:0]  rd_addr;
   logic [15:0]        w_data;
   logic [15:0]        s_data;
   logic               div_start;
   logic [31:0]        div_dividend;
   logic [SUM_W-1:0]   div_divisor;
   logic               div_done;
   logic [SUM_W-1:0]   div_rem;
   logic               scanning;
   logic               out_free;

   assign n = (32'(server_count) > 32'(MAX_SERVERS)) ? N_MAX : CNT_W'(server_count);
   assign wr_addr = SLOT_W'(cmd.slot);
   assign rd_addr = issue_ff[SLOT_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign scanning = (state_ff == bss_pkg::ST_SUM || state_ff == bss_pkg::ST_WALK ||
                      state_ff == bss_pkg::ST_LEAST) && (issue_ff != n);

   bss_ram #(.WIDTH(16), .DEPTH(MAX_SERVERS)) u_weight_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd.weight),
      .rd_addr (rd_addr),
      .rd_data (w_data)
   );

   bss_ram #(.WIDTH(16), .DEPTH(MAX_SERVERS)) u_session_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd.sessions),
      .rd_addr (rd_addr),
      .rd_data (s_data)
   );

   bss_divider #(.SUM_W(SUM_W)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      counter_in   = counter_ff;
      wrr_dvd_in   = wrr_dvd_ff;
      sum_in       = sum_ff;
      walk_in      = walk_ff;
      best_in      = best_ff;
      best_val_in  = best_val_ff;
      issue_in     = issue_ff;
      rd_vld_in    = 1'b0;
      rd_last_in   = rd_last_ff;
      rd_idx_in    = rd_idx_ff;
      res_slot_in  = res_slot_ff;
      res_none_in  = res_none_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_none_in  = rsp_none_ff;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      div_start    = 1'b0;
      div_dividend = counter_ff;
      div_divisor  = SUM_W'(n);

      // issue one table read per cycle while scanning
      if (scanning) begin
         rd_vld_in  = 1'b1;
         rd_last_in = (issue_ff == n - CNT_W'(1));
         rd_idx_in  = issue_ff[SLOT_W-1:0];
         issue_in   = issue_ff + CNT_W'(1);
      end

      unique case (state_ff)
         bss_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               issue_in = '0;
               if (cmd.kind == bss_pkg::CMD_UPDATE) begin
                  wr_en = 1'b1;
               end else if (n == '0) begin
                  res_slot_in = '0;
                  res_none_in = 1'b1;
                  state_in    = bss_pkg::ST_RESP;
               end else begin
                  unique case (mode)
                     bss_pkg::MODE_RR: begin
                        div_start  = 1'b1;
                        counter_in = counter_ff + 32'd1;
                        state_in   = bss_pkg::ST_DIV;
                     end
                     bss_pkg::MODE_WRR: begin
                        wrr_dvd_in = counter_ff;
                        counter_in = counter_ff + 32'd1;
                        sum_in     = '0;
                        state_in   = bss_pkg::ST_SUM;
                     end
                     bss_pkg::MODE_LEAST: begin
                        state_in = bss_pkg::ST_LEAST;
                     end
                     bss_pkg::MODE_HASH: begin
                        div_start    = 1'b1;
                        div_dividend = cmd.addr;
                        state_in     = bss_pkg::ST_DIV;
                     end
                     default: state_in = bss_pkg::ST_IDLE;
                  endcase
               end
            end
         end
         bss_pkg::ST_SUM: begin
            div_dividend = wrr_dvd_ff;
            if (rd_vld_ff) begin
               sum_in      = sum_ff + SUM_W'(w_data);
               div_divisor = sum_in;
               if (rd_last_ff) begin
                  if (sum_in == '0) begin
                     res_slot_in = '0;
                     res_none_in = 1'b1;
                     state_in    = bss_pkg::ST_RESP;
                  end else begin
                     div_start = 1'b1;
                     state_in  = bss_pkg::ST_DIV;
                  end
               end
            end
         end
         bss_pkg::ST_DIV: begin
            if (div_done) begin
               if (mode == bss_pkg::MODE_WRR) begin
                  walk_in  = div_rem;
                  issue_in = '0;
                  state_in = bss_pkg::ST_WALK;
               end else begin
                  res_slot_in = 4'(div_rem);
                  res_none_in = 1'b0;
                  state_in    = bss_pkg::ST_RESP;
               end
            end
         end
         bss_pkg::ST_WALK: begin
            if (rd_vld_ff) begin
               if (walk_ff < SUM_W'(w_data)) begin
                  res_slot_in = 4'(rd_idx_ff);
                  res_none_in = 1'b0;
                  state_in    = bss_pkg::ST_RESP;
               end else begin
                  walk_in = walk_ff - SUM_W'(w_data);
                  if (rd_last_ff) begin
                     res_slot_in = '0;
                     res_none_in = 1'b1;
                     state_in    = bss_pkg::ST_RESP;
                  end
               end
            end
         end
         bss_pkg::ST_LEAST: begin
            if (rd_vld_ff) begin
               if (rd_idx_ff == '0 || s_data < best_val_ff) begin
                  best_in     = rd_idx_ff;
                  best_val_in = s_data;
               end
               if (rd_last_ff) begin
                  res_slot_in = 4'(best_in);
                  res_none_in = 1'b0;
                  state_in    = bss_pkg::ST_RESP;
               end
            end
         end
         bss_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = res_slot_ff;
               rsp_none_in  = res_none_ff;
               state_in     = bss_pkg::ST_IDLE;
            end
         end
         default: state_in = bss_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bss_pkg::ST_IDLE;
         counter_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wrr_dvd_ff  <= wrr_dvd_in;
      sum_ff      <= sum_in;
      walk_ff     <= walk_in;
      best_ff     <= best_in;
      best_val_ff <= best_val_in;
      issue_ff    <= issue_in;
      rd_last_ff  <= rd_last_in;
      rd_idx_ff   <= rd_idx_in;
      res_slot_ff <= res_slot_in;
      res_none_ff <= res_none_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_none_ff <= rsp_none_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_slot_ff};
   assign rsp_tuser  = rsp_none_ff;

   `BSS_ASSERT_IMP(a_div_done_in_div, clock, reset, div_done,
      state_ff == bss_pkg::ST_DIV, "divider finished outside the divide state")
   `BSS_ASSERT_IMP(a_scan_in_range, clock, reset, rd_vld_ff,
      CNT_W'(rd_idx_ff) < n, "table read beyond the active server count")
   `BSS_ASSERT_NXT(a_counter_hold, clock, reset,
      !(state_ff == bss_pkg::ST_IDLE && cmd_valid && cmd.kind == bss_pkg::CMD_SELECT),
      $stable(counter_ff), "rotation counter moved without a select dispatch")

endmodule

// ===== sv/backend_server_selector_unit.sv =====
// Backend server selector.
// Request channel req_*: req_tuser = 0 writes the weight and session count of
// one slot and returns nothing; req_tuser = 1 asks for a server and returns one
// response. Response channel rsp_*: chosen slot in rsp_tdata, rsp_tuser = 1 when
// no server could be chosen. Register port csr_*: index 0 mode (round robin,
// weighted round robin, least sessions, address hash), index 1 server count.
// Requests pass through a two-entry queue to the selection engine, so the
// sender is stalled only when that queue is full.
// Per select, with n active servers: round robin and hash use the 32-step
// remainder unit; least sessions scans the table at one read per cycle;
// weighted does a sum scan, the remainder and a walk scan. An update is a
// single table write. With zero servers a select answers without a scan.
// The response register holds a result until it is taken; while the receiver
// stalls, the engine holds the next result and the queue accepts until full.
// Reset clears mode, server count, rotation counter, queue and response.
// The slot tables are not cleared: a slot must be written before it is used.
module backend_server_selector_unit #(
   parameter int MAX_SERVERS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // server_slot, server_weight, live_sessions, client_addr, zero pad
   input  logic [bss_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // chosen_slot, zero pad
   output logic [bss_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // none_found
   output logic                             rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bss_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bss_pkg::CSR_DATA_W-1:0]   csr_data
);

   bss_pkg::mode_type mode_ff, mode_in;
   logic [4:0]        count_ff, count_in;
   logic              cmd_valid;
   bss_pkg::cmd_type  cmd;
   logic              cmd_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == bss_pkg::CSR_MODE) begin
            mode_in = bss_pkg::mode_type'(csr_data[1:0]);
         end else if (csr_index == bss_pkg::CSR_COUNT) begin
            count_in = csr_data[4:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= bss_pkg::MODE_RR;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   bss_front #(.MAX_SERVERS(MAX_SERVERS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   bss_engine #(.MAX_SERVERS(MAX_SERVERS)) u_engine (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop),
      .mode         (mode_ff),
      .server_count (count_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

// ===== tb/backend_server_selector_unit_tb.sv =====
module backend_server_selector_unit_tb;

   localparam int          SLOTS          = 16;
   localparam int          ITEM_TARGET    = 1050;
   localparam int          SETTLE_CYCLES  = 80;
   localparam int          STALL_LIMIT    = 3000;

   typedef struct {
      logic [3:0] slot;
      logic       none;
   } choice_type;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [bss_pkg::REQ_DATA_W-1:0]    req_tdata  = '0;
   logic                              req_tuser  = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [bss_pkg::RSP_DATA_W-1:0]    rsp_tdata;
   logic                              rsp_tuser;
   logic                              csr_valid  = 1'b0;
   logic                              csr_ready;
   logic [bss_pkg::CSR_INDEX_W-1:0]   csr_index  = bss_pkg::CSR_MODE;
   logic [bss_pkg::CSR_DATA_W-1:0]    csr_data   = '0;

   bss_pkg::mode_type        mode_reg;
   logic [4:0]               count_reg;
   logic [31:0]              rotation;
   logic [15:0]              weight_tab [SLOTS];
   logic [15:0]              session_tab [SLOTS];
   logic [SLOTS-1:0]         slot_written;

   choice_type               expected_choices [$];
   choice_type               front_choice;
   bit                       no_idle;
   int                       mismatches;
   int                       stall_cycles;
   int                       items_sent;
   int                       selects_sent;
   int                       settings_used;
   int                       results_seen;
   int                       none_seen;

   backend_server_selector_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(99) >= 14);
   end

   task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch on %s: expected %0d, got %0d", what, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tuser) begin
            none_seen++;
         end
         if (expected_choices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response with nothing pending: slot %0d, none %0d",
                        rsp_tdata[3:0], rsp_tuser);
            end
         end else begin
            front_choice = expected_choices.pop_front();
            if (rsp_tdata[3:0] !== front_choice.slot) begin
               flag_mismatch("chosen_slot", front_choice.slot, rsp_tdata[3:0]);
            end
            if (rsp_tuser !== front_choice.none) begin
               flag_mismatch("none_found", front_choice.none, rsp_tuser);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles, %0d responses pending",
                     stall_cycles, expected_choices.size());
            $display("FAIL backend_server_selector_unit");
            $finish;
         end
      end
   end

   task automatic predict_selection(bss_pkg::cmd_kind_type kind, logic [3:0] slot,
                                    logic [15:0] weight, logic [15:0] sessions,
                                    logic [31:0] addr);
      choice_type     pick;
      int unsigned    active;
      int unsigned    best;
      longint unsigned total;
      longint unsigned pos;
      pick.slot = 4'd0;
      pick.none = 1'b1;
      if (kind == bss_pkg::CMD_UPDATE) begin
         weight_tab[slot]  = weight;
         session_tab[slot] = sessions;
         return;
      end
      active = (count_reg > SLOTS) ? SLOTS : count_reg;
      if (active != 0) begin
         unique case (mode_reg)
            bss_pkg::MODE_RR: begin
               pick.slot = 4'(rotation % active);
               pick.none = 1'b0;
               rotation  = rotation + 32'd1;
            end
            bss_pkg::MODE_WRR: begin
               total = 0;
               for (int unsigned i = 0; i < active; i++) begin
                  total += weight_tab[i];
               end
               pos      = rotation;
               rotation = rotation + 32'd1;
               if (total != 0) begin
                  pos = pos % total;
                  for (int unsigned i = 0; i < active; i++) begin
                     if (pick.none) begin
                        if (pos < weight_tab[i]) begin
                           pick.slot = 4'(i);
                           pick.none = 1'b0;
                        end else begin
                           pos -= weight_tab[i];
                        end
                     end
                  end
               end
            end
            bss_pkg::MODE_LEAST: begin
               best = 0;
               for (int unsigned i = 1; i < active; i++) begin
                  if (session_tab[i] < session_tab[best]) begin
                     best = i;
                  end
               end
               pick.slot = 4'(best);
               pick.none = 1'b0;
            end
            default: begin
               pick.slot = 4'(addr % active);
               pick.none = 1'b0;
            end
         endcase
      end
      expected_choices.push_back(pick);
   endtask

   task automatic send_request(bss_pkg::cmd_kind_type kind, logic [3:0] slot,
                               logic [15:0] weight, logic [15:0] sessions,
                               logic [31:0] addr);
      while (!no_idle && $urandom_range(99) < 14) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, addr, sessions, weight, slot};
      do @(posedge clock); while (!req_tready);
      predict_selection(kind, slot, weight, sessions, addr);
      items_sent++;
      if (kind == bss_pkg::CMD_UPDATE) begin
         slot_written[slot] = 1'b1;
      end else begin
         selects_sent++;
      end
   endtask

   task automatic send_update(logic [3:0] slot, logic [15:0] weight, logic [15:0] sessions);
      send_request(bss_pkg::CMD_UPDATE, slot, weight, sessions, $urandom);
   endtask

   task automatic send_select(logic [31:0] addr);
      send_request(bss_pkg::CMD_SELECT, 4'($urandom), 16'($urandom), 16'($urandom), addr);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_choices.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(bss_pkg::mode_type mode, logic [4:0] count);
      settle();
      csr_valid <= 1'b1;
      csr_index <= bss_pkg::CSR_MODE;
      csr_data  <= {6'b0, mode};
      do @(posedge clock); while (!csr_ready);
      mode_reg = mode;
      csr_index <= bss_pkg::CSR_COUNT;
      csr_data  <= {3'b0, count};
      do @(posedge clock); while (!csr_ready);
      count_reg = count;
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [15:0] random_level();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 55) return 16'($urandom_range(7));
      if (r < 65) return 16'd0;
      if (r < 75) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic logic [31:0] random_addr();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 3) return 32'd0;
      if (r < 6) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   task automatic test_zero_servers();
      configure(bss_pkg::MODE_RR, 5'd0);
      send_select(random_addr());
      configure(bss_pkg::MODE_WRR, 5'd0);
      send_select(random_addr());
      configure(bss_pkg::MODE_LEAST, 5'd0);
      send_select(random_addr());
      configure(bss_pkg::MODE_HASH, 5'd0);
      send_select(32'hFFFF_FFFF);
   endtask

   task automatic test_slot_updates();
      send_update(4'd0, 16'd0, 16'hFFFF);
      send_update(4'd1, 16'd0, 16'd0);
      send_update(4'd2, 16'hFFFF, 16'd0);
      send_update(4'd3, 16'd1, 16'd0);
      send_update(4'd15, 16'hFFFF, 16'hFFFF);
   endtask

   task automatic test_round_robin();
      configure(bss_pkg::MODE_RR, 5'd3);
      repeat (3) send_select(random_addr());
   endtask

   task automatic test_zero_weight_sum();
      configure(bss_pkg::MODE_WRR, 5'd2);
      send_select(random_addr());
   endtask

   task automatic test_weighted();
      configure(bss_pkg::MODE_WRR, 5'd4);
      repeat (3) send_select(random_addr());
   endtask

   task automatic test_least_sessions();
      configure(bss_pkg::MODE_LEAST, 5'd4);
      send_select(random_addr());
   endtask

   task automatic test_address_hash();
      configure(bss_pkg::MODE_HASH, 5'd3);
      send_select(32'd0);
      send_select(32'hFFFF_FFFF);
      send_select($urandom);
   endtask

   task automatic test_oversized_count();
      configure(bss_pkg::MODE_HASH, 5'd31);
      send_select(32'hFFFF_FFFF);
      configure(bss_pkg::MODE_RR, 5'd17);
      send_select(random_addr());
   endtask

   task automatic test_random_traffic();
      int          phase;
      int unsigned r;
      int unsigned count;
      int unsigned active;
      int unsigned len;
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         r = $urandom_range(99);
         if (r < 5) count = 0;
         else if (r < 15) count = SLOTS;
         else if (r < 20) count = $urandom_range(31, SLOTS + 1);
         else count = $urandom_range(SLOTS - 1, 1);
         configure(bss_pkg::mode_type'($urandom_range(3)), 5'(count));
         no_idle = (phase == 4);
         active = (count > SLOTS) ? SLOTS : count;
         for (int unsigned s = 0; s < active; s++) begin
            if (!slot_written[s]) begin
               send_update(4'(s), random_level(), random_level());
            end
         end
         len = $urandom_range(60, 20);
         repeat (len) begin
            if ($urandom_range(99) < 70) begin
               send_select(random_addr());
            end else begin
               send_update(4'($urandom_range(SLOTS - 1)), random_level(), random_level());
            end
         end
         phase++;
      end
      no_idle = 1'b0;
   endtask

   initial begin
      slot_written = '0;
      rotation     = '0;
      mode_reg     = bss_pkg::MODE_RR;
      count_reg    = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_zero_servers();
      test_slot_updates();
      test_round_robin();
      test_zero_weight_sum();
      test_weighted();
      test_least_sessions();
      test_address_hash();
      test_oversized_count();
      test_random_traffic();
      settle();
      mismatches += expected_choices.size();
      $display("sent %0d requests (%0d selects, %0d slot updates) across %0d mode/count settings",
               items_sent, selects_sent, items_sent - selects_sent, settings_used);
      $display("checked %0d responses, %0d of them with no server available",
               results_seen, none_seen);
      if (mismatches == 0) begin
         $display("PASS backend_server_selector_unit");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL backend_server_selector_unit");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/bss_pkg.sv
sv/bss_ram.sv
sv/bss_front.sv
sv/bss_divider.sv
sv/bss_engine.sv
sv/backend_server_selector_unit.sv
tb/backend_server_selector_unit_tb.sv
